// ===== rtl/binary_to_padded_decimal_digits_core_macros.svh =====
// -----------------------------------------------------------------------------
// binary_to_padded_decimal_digits_core_macros.svh
// Assertion macros shared by the decimal digit splitter.
// -----------------------------------------------------------------------------
`ifndef BINARY_TO_PADDED_DECIMAL_DIGITS_CORE_MACROS_SVH
`define BINARY_TO_PADDED_DECIMAL_DIGITS_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, ignored while aresetn is low.
`define BPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, ignored while aresetn is low.
`define BPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpd_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpd_pkg
// Word types, constants and chain control shared by the digit splitter.
// -----------------------------------------------------------------------------
package bpd_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned BUF_LEN_W  = 5;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [BUF_LEN_W-1:0] buf_len;
        logic [4:0]           min_width;
        logic                 count_only;
    } in_word_t;

    typedef struct packed {
        logic [3:0] digit;
        logic [3:0] position;
        logic       digit_valid;
        logic [4:0] digit_count;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctrl_t;

endpackage

// ===== rtl/binary_to_padded_decimal_digits_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// binary_to_padded_decimal_digits_core
// Splits a 32-bit unsigned value into zero-padded decimal digit words.
// -----------------------------------------------------------------------------
// One input word at a time: s_ready is high only while the block is idle.
// The value is converted by a row of ten BCD cells, one bit per cycle; then
// the field length is set up in its own state, and the digit words are
// emitted one at a time, each waiting while the output slot is still full.
// A count-only request returns one word.
// Results leave through a registered output slot, so a pending final word
// does not hold off the next input. Digits come most significant first:
// leading zeros, then the low n decimal digits; the final word has last set.
// A count-only request (count_only set, or buf_len of zero) returns a single
// word with digit_valid low and digit_count holding the natural digit count.
// buf_len above MAX_LEN saturates to MAX_LEN.
// -----------------------------------------------------------------------------
`include "binary_to_padded_decimal_digits_core_macros.svh"

module binary_to_padded_decimal_digits_core #(
    parameter int unsigned MAX_LEN = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bpd_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bpd_pkg::out_word_t  m_data
);
    import bpd_pkg::*;

    // buf_len cannot exceed its own field range, so cap there as well
    localparam int unsigned BufLenMax = (1 << BUF_LEN_W) - 1;
    localparam int unsigned LenCapInt = (MAX_LEN < BufLenMax) ? MAX_LEN : BufLenMax;
    localparam logic [BUF_LEN_W-1:0] LEN_CAP = BUF_LEN_W'(LenCapInt);
    localparam logic [4:0] CONV_LAST = 5'(VALUE_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    logic [4:0]                      bit_cnt_reg;
    logic [BUF_LEN_W-1:0]            len_reg;
    logic [4:0]                      minw_reg;
    logic                            conly_reg;
    logic [4:0]                      field_len_reg;
    logic [4:0]                      pads_reg;
    logic [3:0]                      count_reg;
    logic [4:0]                      p_reg;
    logic                            m_valid_reg;
    out_word_t                       m_data_reg;

    chain_ctrl_t                     ctrl;
    bcd_t [NUM_DIGITS-1:0]           digits;
    logic                            accept;
    logic                            load_out;
    logic                            emit_word;

    logic [3:0]                      n_nat;
    logic [4:0]                      n_clip;
    logic [4:0]                      field_len;
    logic [4:0]                      pads;
    logic [4:0]                      rank;
    logic                            last_emit;
    out_word_t                       word;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign load_out  = !m_valid_reg || m_ready;
    assign emit_word = (state_reg == ST_EMIT) && load_out;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Clear and load the chain on acceptance; shift it through conversion.
    assign ctrl.load  = accept;
    assign ctrl.shift = (state_reg == ST_CONV);

    bpd_chain u_chain (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .value  (s_data.value),
        .digits (digits)
    );

    // Natural digit count: one above the highest nonzero digit, at least one.
    always_comb begin
        n_nat = 4'd1;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (digits[i] != 4'd0) begin
                n_nat = 4'(i + 1);
            end
        end
    end

    // Field length: clip n to the buffer, then widen to the minimum width
    // unless the minimum width already covers the whole buffer.
    always_comb begin
        n_clip = (5'(n_nat) > len_reg) ? len_reg : 5'(n_nat);
        if (minw_reg >= len_reg) begin
            field_len = len_reg;
        end else begin
            field_len = (n_clip > minw_reg) ? n_clip : minw_reg;
        end
        pads = field_len - n_clip;
    end

    // Build the next result word from the emit position.
    always_comb begin
        rank      = field_len_reg - 5'd1 - p_reg;
        last_emit = conly_reg || (p_reg + 5'd1 == field_len_reg);
        word      = '0;
        if (conly_reg) begin
            word.digit_count = 5'(count_reg);
            word.last        = 1'b1;
        end else begin
            if (p_reg >= pads_reg && rank < 5'(NUM_DIGITS)) begin
                word.digit = digits[rank[3:0]];
            end
            word.position    = p_reg[3:0];
            word.digit_valid = 1'b1;
            word.digit_count = field_len_reg;
            word.last        = last_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Raise the output word as it is loaded; drop it once the sink
            // has taken it.
            if (emit_word) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        bit_cnt_reg <= '0;
                        len_reg     <= (s_data.buf_len > LEN_CAP) ? LEN_CAP : s_data.buf_len;
                        minw_reg    <= s_data.min_width;
                        conly_reg   <= s_data.count_only || (s_data.buf_len == '0);
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    // Advance one bit per cycle until all value bits are in.
                    bit_cnt_reg <= bit_cnt_reg + 5'd1;
                    if (bit_cnt_reg == CONV_LAST) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    field_len_reg <= field_len;
                    pads_reg      <= pads;
                    count_reg     <= n_nat;
                    p_reg         <= '0;
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Hold until the output slot is free, then advance.
                    if (load_out) begin
                        m_data_reg  <= word;
                        p_reg       <= p_reg + 5'd1;
                        if (last_emit) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `BPD_ASSERT_NEXT(a_accept_starts_conv, accept, state_reg == ST_CONV,
                     "accept did not start conversion")
    `BPD_ASSERT_NEXT(a_conv_len, state_reg == ST_CONV && bit_cnt_reg == CONV_LAST,
                     state_reg == ST_PREP, "conversion length wrong")
    `BPD_ASSERT_IMPL(a_emit_in_field, state_reg == ST_EMIT && !conly_reg,
                     p_reg < field_len_reg, "emit position beyond field")
    `BPD_ASSERT_IMPL(a_digit_decimal, m_valid_reg, m_data_reg.digit <= 4'd9,
                     "non-decimal digit emitted")
    `BPD_ASSERT_IMPL(a_count_only_last, m_valid_reg && !m_data_reg.digit_valid,
                     m_data_reg.last, "count word not marked last")

endmodule

// ===== rtl/bpd_cell.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpd_cell
// One BCD digit of the shift-and-add-3 chain.
// -----------------------------------------------------------------------------
module bpd_cell (
    input  logic                  aclk,
    input  bpd_pkg::chain_ctrl_t  ctrl,
    input  logic                  shift_in,
    output logic                  shift_out,
    output bpd_pkg::bcd_t         digit
);
    import bpd_pkg::*;

    bcd_t digit_reg;
    bcd_t adj;
    bcd_t digit_next;

    // Correct by 3 when the digit would overflow past 9 on the doubling shift.
    always_comb begin
        adj        = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        digit_next = {adj[2:0], shift_in};
    end

    assign shift_out = adj[3];
    assign digit     = digit_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            digit_reg <= '0;
        end else if (ctrl.shift) begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== rtl/bpd_chain.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpd_chain
// Binary shift register feeding a row of BCD digit cells.
// -----------------------------------------------------------------------------
module bpd_chain (
    input  logic                                       aclk,
    input  bpd_pkg::chain_ctrl_t                       ctrl,
    input  logic [bpd_pkg::VALUE_W-1:0]                value,
    output bpd_pkg::bcd_t [bpd_pkg::NUM_DIGITS-1:0]    digits
);
    import bpd_pkg::*;

    logic [VALUE_W-1:0]    value_reg;
    logic [NUM_DIGITS-2:0] carry;

    // Load the value, then shift it out MSB first into the lowest digit.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            value_reg <= value;
        end else if (ctrl.shift) begin
            value_reg <= {value_reg[VALUE_W-2:0], 1'b0};
        end
    end

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            bpd_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .shift_in  (value_reg[VALUE_W-1]),
                .shift_out (carry[i]),
                .digit     (digits[i])
            );
        end else if (i == NUM_DIGITS - 1) begin : g_top
            // A 32-bit value never carries out of the tenth decimal digit.
            bpd_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .shift_in  (carry[i-1]),
                .shift_out (),
                .digit     (digits[i])
            );
        end else begin : g_mid
            bpd_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .shift_in  (carry[i-1]),
                .shift_out (carry[i]),
                .digit     (digits[i])
            );
        end
    end

endmodule

// ===== test/bpd_digit_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpd_digit_checker
// Watches both channels of the decimal digit splitter, works out the digit
// words each accepted request must produce and compares them in order.
// -----------------------------------------------------------------------------
module bpd_digit_checker #(
    parameter int unsigned MAX_LEN = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  bpd_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  bpd_pkg::out_word_t m_data,
    output int                 fail_count,
    output int                 pending_words,
    output int                 requests_seen,
    output int                 words_checked,
    output int                 counts_checked
);

    import bpd_pkg::*;

    localparam int PRINT_LIMIT = 40;

    out_word_t digit_words_due[$];

    initial begin
        fail_count     = 0;
        pending_words  = 0;
        requests_seen  = 0;
        words_checked  = 0;
        counts_checked = 0;
    end

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s expected %0d got %0d (word %0d)",
                     $realtime, what, want, got, words_checked);
        end
    endtask

    // Queue the digit words one request must produce.
    function automatic void queue_digit_words(in_word_t req);
        longint unsigned limit;
        longint unsigned scaled;
        int unsigned     natural;
        int unsigned     span;
        int unsigned     shown;
        int unsigned     field;
        int unsigned     pads;
        out_word_t       w;

        natural = 1;
        limit   = 10;
        while (natural < 10 && longint'(req.value) >= limit) begin
            natural++;
            limit = limit * 10;
        end

        if (req.count_only || req.buf_len == '0) begin
            w             = '0;
            w.digit_count = 5'(natural);
            w.last        = 1'b1;
            digit_words_due.push_back(w);
            return;
        end

        span  = (req.buf_len > MAX_LEN) ? MAX_LEN : req.buf_len;
        shown = (natural > span) ? span : natural;
        if (req.min_width >= span) field = span;
        else field = (shown > req.min_width) ? shown : req.min_width;
        pads = field - shown;

        for (int unsigned p = 0; p < field; p++) begin
            w             = '0;
            w.position    = 4'(p);
            w.digit_valid = 1'b1;
            w.digit_count = 5'(field);
            w.last        = (p + 1 == field);
            if (p >= pads) begin
                scaled = longint'(req.value);
                for (int unsigned r = 0; r < field - 1 - p; r++) scaled = scaled / 10;
                w.digit = 4'(scaled % 10);
            end
            digit_words_due.push_back(w);
        end
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                queue_digit_words(s_data);
                requests_seen++;
            end
            if (m_valid && m_ready) begin
                if (digit_words_due.size() == 0) begin
                    report_mismatch("unexpected word, queued", 0, 1);
                end else begin
                    want = digit_words_due.pop_front();
                    if (m_data.digit !== want.digit)
                        report_mismatch("digit", want.digit, m_data.digit);
                    if (m_data.position !== want.position)
                        report_mismatch("position", want.position, m_data.position);
                    if (m_data.digit_valid !== want.digit_valid)
                        report_mismatch("digit_valid", want.digit_valid, m_data.digit_valid);
                    if (m_data.digit_count !== want.digit_count)
                        report_mismatch("digit_count", want.digit_count, m_data.digit_count);
                    if (m_data.last !== want.last)
                        report_mismatch("last", want.last, m_data.last);
                    if (!want.digit_valid) counts_checked++;
                end
                words_checked++;
            end
            pending_words = digit_words_due.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Drives requests into the decimal digit splitter: a directed set of edge
// cases, then random values, lengths and widths under random idling on both
// channels and one long output hold-off; the checker judges every word.
// -----------------------------------------------------------------------------
module tb;

    import bpd_pkg::*;

    localparam int unsigned MAX_LEN     = 16;
    localparam int          RANDOM_REQS = 205;
    localparam int          HOLD_CYCLES = 400;   // long output back-pressure
    localparam int          QUIET_LIMIT = 4000;  // cycles with no word moving
    localparam int          DRAIN_WAIT  = 80;    // wait after the drain for a stray late word

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int fail_count;
    int pending_words;
    int requests_seen;
    int words_checked;
    int counts_checked;

    // Stimulus controls shared with the receiver process, and the watchdog count.
    bit gaps_on;
    bit hold_asked;
    bit hold_done;
    int quiet_cycles;

    binary_to_padded_decimal_digits_core #(.MAX_LEN(MAX_LEN)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bpd_digit_checker #(.MAX_LEN(MAX_LEN)) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .fail_count     (fail_count),
        .pending_words  (pending_words),
        .requests_seen  (requests_seen),
        .words_checked  (words_checked),
        .counts_checked (counts_checked)
    );

    // 4 ns clock: 2 ns low, 2 ns high.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Build one request word from its fields.
    function automatic in_word_t make_request(logic [31:0] value, int unsigned len,
                                              int unsigned width, bit count_only);
        in_word_t w;
        w.value      = value;
        w.buf_len    = 5'(len);
        w.min_width  = 5'(width);
        w.count_only = count_only;
        return w;
    endfunction

    // Pick a value: mostly spread evenly over digit counts, sometimes a
    // power-of-ten boundary, sometimes fully random.
    function automatic logic [31:0] pick_value();
        longint unsigned lo;
        longint unsigned hi;
        int unsigned     k;
        lo = 1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: begin
                k = $urandom_range(1, 9);
                for (int unsigned i = 0; i < k; i++) lo = lo * 10;
                return 32'($urandom_range(0, 1) ? lo : lo - 1);
            end
            default: begin
                k = $urandom_range(1, 10);
                for (int unsigned i = 1; i < k; i++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (k == 1) lo = 0;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
            end
        endcase
    endfunction

    function automatic in_word_t pick_request();
        int unsigned len;
        int unsigned width;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(17, 31);
            default: len = $urandom_range(1, 16);
        endcase
        width = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
        return make_request(pick_value(), len, width, $urandom_range(0, 7) == 0);
    endfunction

    // Offer one request word, after an optional idle burst, and hold it
    // until the block takes it.
    task automatic offer_request(in_word_t req);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int unsigned stall;
        int unsigned hold;
        bit          take;
        stall   = 0;
        hold    = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asked && !hold_done) begin
                hold_done = 1'b1;
                hold      = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                take = 1'b0;
            end else if (stall > 0) begin
                stall--;
                take = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 18);
                take  = 1'b0;
            end else begin
                take = 1'b1;
            end
            m_ready <= take;
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        in_word_t directed[$];

        s_valid      <= 1'b0;
        s_data       <= '0;
        aresetn      <= 1'b0;
        gaps_on      = 1'b0;
        hold_asked   = 1'b0;

        // Single zero digit, full 32-bit value, clipping to a short buffer.
        directed.push_back(make_request(32'd0,          1,  0,  1'b0));
        directed.push_back(make_request(32'hFFFF_FFFF,  16, 0,  1'b0));
        directed.push_back(make_request(32'hFFFF_FFFF,  10, 16, 1'b0));
        directed.push_back(make_request(32'hFFFF_FFFF,  5,  0,  1'b0));
        directed.push_back(make_request(32'd1000000000, 9,  0,  1'b0));
        directed.push_back(make_request(32'd10,         1,  0,  1'b0));
        // Count-only answers: flag set, zero length, both together.
        directed.push_back(make_request(32'd1234567,    8,  0,  1'b1));
        directed.push_back(make_request(32'd999999999,  0,  0,  1'b0));
        directed.push_back(make_request(32'hFFFF_FFFF,  0,  31, 1'b1));
        directed.push_back(make_request(32'd0,          31, 31, 1'b1));
        // Lengths above the maximum saturate.
        directed.push_back(make_request(32'd12345,      31, 0,  1'b0));
        directed.push_back(make_request(32'd12345,      31, 31, 1'b0));
        directed.push_back(make_request(32'd8675309,    20, 12, 1'b0));
        directed.push_back(make_request(32'd4000000000, 17, 17, 1'b0));
        // Minimum width padding and its interplay with the length.
        directed.push_back(make_request(32'd9,          16, 15, 1'b0));
        directed.push_back(make_request(32'd7,          3,  3,  1'b0));
        directed.push_back(make_request(32'd42,         4,  2,  1'b0));
        directed.push_back(make_request(32'd42,         4,  1,  1'b0));
        directed.push_back(make_request(32'd1000000000, 16, 3,  1'b0));
        directed.push_back(make_request(32'd305419896,  16, 31, 1'b0));
        directed.push_back(make_request(32'd99,         2,  16, 1'b0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) offer_request(directed[i]);

        // Random requests under idling on both sides; a long output hold
        // lands in the middle so the block backs up into its input.
        gaps_on = 1'b1;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i == 70) hold_asked = 1'b1;
            if (i == RANDOM_REQS - 40) gaps_on = 1'b0;
            offer_request(pick_request());
        end
        s_valid <= 1'b0;
        // Let the checker queue the last request before looking at the count.
        @(posedge aclk);

        // Drain, then give the block time for a stray late word.
        while (pending_words != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("run: %0d requests, %0d words checked, %0d of them count-only answers",
                 requests_seen, words_checked, counts_checked);
        $display("run: output held off for %0d cycles once, %0d mismatches",
                 HOLD_CYCLES, fail_count);
        if (pending_words != 0) begin
            $display("run: %0d expected words never arrived", pending_words);
        end
        if (fail_count == 0 && pending_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bpd_pkg.sv
rtl/bpd_cell.sv
rtl/bpd_chain.sv
rtl/binary_to_padded_decimal_digits_core.sv
test/bpd_digit_checker.sv
test/tb.sv
